### rtl/core/esbk_pkg.sv
// Shared types and constants for the exchange sort block.
package esbk_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned KEY_W         = 16;
  localparam int unsigned TAG_W         = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WR_I,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // controller -> datapath commands
  typedef struct packed {
    logic wr_en;      // write store
    logic wr_sel_a;   // write data from held record, else from input
    logic ld_a;       // load held record from read data
    logic cmp_en;     // compare held record against read data
    logic emit;       // read data goes out next cycle
    logic emit_last;  // ... and it is the last of the run
  } cmd_t;

endpackage

### rtl/core/exchange_sort_by_key.sv
// Top level of the exchange sort: collects records, sorts by key, streams them out.
// Loading: one record per cycle while busy is low; the record marked final starts the run.
// Sort of n records: one key compare per cycle through the store's single read port,
//   then the n sorted records leave, one result per cycle.
// Results leave as a strobe burst the receiver cannot stall; busy falls with the last one.
// Reset (rst_ni low, async) empties the set and selects ascending order.
module exchange_sort_by_key #(
  parameter int unsigned DEPTH = esbk_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // sort_mode register: 0 ascending, 1 descending
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  // input records; transfer when start is high and busy is low
  input  logic                        start,
  output logic                        busy,
  input  logic [esbk_pkg::KEY_W-1:0]  record_key_i,
  input  logic [esbk_pkg::TAG_W-1:0]  record_tag_i,
  input  logic                        is_final_i,
  // sorted results; one transfer per cycle with result_valid_o high
  output logic                        result_valid_o,
  output logic [esbk_pkg::KEY_W-1:0]  sorted_key_o,
  output logic [esbk_pkg::TAG_W-1:0]  sorted_tag_o,
  output logic                        end_of_run_o
);

  esbk_pkg::cmd_t cmd;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           swap;

  // Controller owns the fill count and the i/j/k indices; the store lives in the datapath.
  esbk_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .is_final_i,
    .busy,
    .swap_i    (swap),
    .cmd_o     (cmd),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr)
  );

  // Held record stands for entry i during the inner pass; swaps write it out at j.
  esbk_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .record_key_i,
    .record_tag_i,
    .cmd_i          (cmd),
    .wr_addr_i      (wr_addr),
    .rd_addr_i      (rd_addr),
    .swap_o         (swap),
    .sorted_key_o,
    .sorted_tag_o,
    .end_of_run_o,
    .result_valid_o
  );

endmodule

### rtl/core/esbk_ctrl.sv
// Sequencer: fill count, pair indices and state machine of the exchange sort.
module esbk_ctrl #(
  parameter int unsigned DEPTH = esbk_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                is_final_i,
  output logic                busy,
  input  logic                swap_i,
  output esbk_pkg::cmd_t      cmd_o,
  output logic [AW-1:0]       wr_addr_o,
  output logic [AW-1:0]       rd_addr_o
);

  esbk_pkg::state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          accept;
  logic          has_room;
  logic [CW-1:0] fill_inc;
  logic          j_last, i_last, k_last;

  assign accept   = start && (state_q == esbk_pkg::ST_IDLE);
  assign has_room = fill_q < CW'(DEPTH);
  assign fill_inc = has_room ? fill_q + CW'(1) : fill_q;
  assign j_last   = CW'(j_q) == fill_q - CW'(1);
  assign i_last   = (CW'(i_q) + CW'(2)) >= fill_q;
  assign k_last   = CW'(k_q) == fill_q - CW'(1);

  // next state and counters
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      esbk_pkg::ST_IDLE: begin
        if (accept) begin
          fill_d = fill_inc;
          if (is_final_i) begin
            i_d = '0;
            k_d = '0;
            state_d = (fill_inc >= CW'(2)) ? esbk_pkg::ST_RD_I : esbk_pkg::ST_EMIT;
          end
        end
      end
      esbk_pkg::ST_RD_I: state_d = esbk_pkg::ST_LD_I;
      esbk_pkg::ST_LD_I: begin
        j_d     = i_q + AW'(1);
        state_d = esbk_pkg::ST_CMP;
      end
      esbk_pkg::ST_CMP: begin
        if (j_last) state_d = esbk_pkg::ST_WR_I;
        else        j_d = j_q + AW'(1);
      end
      esbk_pkg::ST_WR_I: begin
        if (i_last) begin
          k_d     = '0;
          state_d = esbk_pkg::ST_EMIT;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = esbk_pkg::ST_RD_I;
        end
      end
      esbk_pkg::ST_EMIT: begin
        if (k_last) begin
          fill_d  = '0;
          state_d = esbk_pkg::ST_IDLE;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      default: state_d = esbk_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o     = '0;
    wr_addr_o = fill_q[AW-1:0];
    rd_addr_o = i_q;
    case (state_q)
      esbk_pkg::ST_IDLE: begin
        cmd_o.wr_en = accept && has_room;
      end
      esbk_pkg::ST_RD_I: rd_addr_o = i_q;
      esbk_pkg::ST_LD_I: begin
        cmd_o.ld_a = 1'b1;
        rd_addr_o  = i_q + AW'(1);
      end
      esbk_pkg::ST_CMP: begin
        cmd_o.cmp_en   = 1'b1;
        cmd_o.wr_en    = swap_i;
        cmd_o.wr_sel_a = 1'b1;
        wr_addr_o      = j_q;
        rd_addr_o      = j_q + AW'(1);
      end
      esbk_pkg::ST_WR_I: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel_a = 1'b1;
        wr_addr_o      = i_q;
      end
      esbk_pkg::ST_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = k_last;
        rd_addr_o       = k_q;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy = state_q != esbk_pkg::ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esbk_pkg::ST_IDLE;
      fill_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

endmodule

### rtl/core/esbk_dpath.sv
// Datapath: record store, held record, key compare and result registers.
module esbk_dpath #(
  parameter int unsigned DEPTH = esbk_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  input  logic [esbk_pkg::KEY_W-1:0]  record_key_i,
  input  logic [esbk_pkg::TAG_W-1:0]  record_tag_i,
  input  esbk_pkg::cmd_t              cmd_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic                        swap_o,
  output logic [esbk_pkg::KEY_W-1:0]  sorted_key_o,
  output logic [esbk_pkg::TAG_W-1:0]  sorted_tag_o,
  output logic                        end_of_run_o,
  output logic                        result_valid_o
);

  esbk_pkg::rec_t mem [DEPTH];
  esbk_pkg::rec_t rd_q;
  esbk_pkg::rec_t a_q, a_d;
  esbk_pkg::rec_t wr_data;
  logic           mode_q;
  logic           valid_q, last_q;
  logic           a_first;

  // held record a comes strictly before the read record
  assign a_first = mode_q ? (a_q.key > rd_q.key) : (a_q.key < rd_q.key);
  assign swap_o  = !a_first;

  assign wr_data = cmd_i.wr_sel_a ? a_q : esbk_pkg::rec_t'{key: record_key_i, tag: record_tag_i};
  assign a_d     = (cmd_i.ld_a || (cmd_i.cmp_en && swap_o)) ? rd_q : a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr_i] <= wr_data;
    rd_q <= mem[rd_addr_i];
    a_q  <= a_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      valid_q <= cmd_i.emit;
      last_q  <= cmd_i.emit_last;
    end
  end

  assign sorted_key_o   = rd_q.key;
  assign sorted_tag_o   = rd_q.tag;
  assign end_of_run_o   = last_q;
  assign result_valid_o = valid_q;

endmodule

### rtl/core/esbk_chk.sv
// Port-level checks for the exchange sort, bound to the top level.
module esbk_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic is_final_i,
  input logic result_valid_o,
  input logic end_of_run_o
);

  // a final record always starts a sort
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && is_final_i |=> busy)
    else $error("final record did not start a sort");

  // the run marker only rides on a result
  a_end_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_run_o |-> result_valid_o)
    else $error("end_of_run without result");

  // results of one run come in an unbroken burst
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !end_of_run_o |=> result_valid_o)
    else $error("gap inside result burst");

  // nothing follows the last result directly
  a_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && end_of_run_o |=> !result_valid_o)
    else $error("result right after end of run");

endmodule

bind exchange_sort_by_key esbk_chk u_esbk_chk (
  .clk_i,
  .rst_ni,
  .start,
  .busy,
  .is_final_i,
  .result_valid_o,
  .end_of_run_o
);

### tb/sv/tb_top.sv
// Self-checking testbench for exchange_sort_by_key: directed table, random record sets.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = esbk_pkg::DEPTH_DEFAULT;
  localparam int unsigned KEY_W = esbk_pkg::KEY_W;
  localparam int unsigned TAG_W = esbk_pkg::TAG_W;

  // Run shape
  localparam int RAND_ITEMS   = 278;     // random transfers, directed table comes first
  localparam int IDLE_PCT     = 6;       // sender gap chance per offered item
  localparam int QUIET_FROM   = 140;     // transfer window with no sender gaps
  localparam int QUIET_TO     = 220;
  localparam int SETTLE_CYCLES = 8;      // pause before a sort_mode write
  localparam int TAIL_CYCLES  = 250;     // > one full-depth sort plus its burst
  localparam int CYCLE_LIMIT  = 200000;  // watchdog limit, well above the worst correct run

  localparam logic MODE_ASC  = 1'b0;
  localparam logic MODE_DESC = 1'b1;

  // sort_mode action taken (while idle) before a directed row
  typedef enum logic [1:0] {CFG_KEEP, CFG_ASC, CFG_DESC} cfg_act_e;

  // key styles for random sets
  typedef enum logic [1:0] {MIX_WIDE, MIX_TIES, MIX_EDGES} key_mix_e;

  // One directed row. rep > 1 issues rep records with stepped key/tag; the
  // final mark, if set, rides on the last copy. typed rows are single-record
  // sets whose result is written out by hand.
  typedef struct packed {
    cfg_act_e    cfg;
    logic [5:0]  rep;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic        fin;
    logic        typed;
    logic [KEY_W-1:0] exp_key;
    logic [TAG_W-1:0] exp_tag;
  } stim_row_t;

  typedef struct packed {
    esbk_pkg::rec_t rec;
    logic last;
  } sorted_rec_t;

  localparam int DIR_ROWS = 17;
  localparam stim_row_t DIR_PLAN [DIR_ROWS] = '{
    // after reset: single records at the key extremes, ascending by default
    '{CFG_KEEP, 6'd1,  16'hFFFF, 8'hA5, 1'b1, 1'b1, 16'hFFFF, 8'hA5},
    '{CFG_KEEP, 6'd1,  16'h0000, 8'h5A, 1'b1, 1'b1, 16'h0000, 8'h5A},
    // equal keys: every pair swaps, tag order follows the pair walk
    '{CFG_KEEP, 6'd1,  16'h0005, 8'h01, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h0005, 8'h02, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h0005, 8'h03, 1'b1, 1'b0, 16'h0000, 8'h00},
    // ascending over the extremes and the mid-scale boundary
    '{CFG_KEEP, 6'd1,  16'hFFFF, 8'h10, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h0000, 8'h11, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h8000, 8'h12, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h7FFF, 8'h13, 1'b1, 1'b0, 16'h0000, 8'h00},
    // descending with a tie
    '{CFG_DESC, 6'd1,  16'h0001, 8'h20, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'hFFFF, 8'h21, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h0001, 8'h22, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h0000, 8'h23, 1'b1, 1'b0, 16'h0000, 8'h00},
    // two-record tie, descending
    '{CFG_KEEP, 6'd1,  16'h1234, 8'hFF, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'h1234, 8'h00, 1'b1, 1'b0, 16'h0000, 8'h00},
    // fill the store, then a final mark that finds it full: dropped, still sorts
    '{CFG_KEEP, 6'd16, 16'h0F00, 8'h40, 1'b0, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP, 6'd1,  16'hABCD, 8'hEE, 1'b1, 1'b0, 16'h0000, 8'h00}
  };

  // DUT ports; the inputs are known from time zero
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic             cfg_data_i   = 1'b0;
  logic             start        = 1'b0;
  logic             busy;
  logic [KEY_W-1:0] record_key_i = '0;
  logic [TAG_W-1:0] record_tag_i = '0;
  logic             is_final_i   = 1'b0;
  logic             result_valid_o;
  logic [KEY_W-1:0] sorted_key_o;
  logic [TAG_W-1:0] sorted_tag_o;
  logic             end_of_run_o;

  exchange_sort_by_key #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .record_key_i  (record_key_i),
    .record_tag_i  (record_tag_i),
    .is_final_i    (is_final_i),
    .result_valid_o(result_valid_o),
    .sorted_key_o  (sorted_key_o),
    .sorted_tag_o  (sorted_tag_o),
    .end_of_run_o  (end_of_run_o)
  );

  // Predictor state: the held set, its fill level and the order selected
  esbk_pkg::rec_t held_recs [DEPTH];
  int          held_count = 0;
  logic        sort_desc  = MODE_ASC;
  sorted_rec_t sorted_due [$];   // sorted records still to come out of the block

  int fail_count  = 0;
  int xfer_count  = 0;
  int cycle_count = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Strict order only; equal keys never precede, so the pair is swapped.
  function automatic logic key_precedes(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return sort_desc ? (a > b) : (a < b);
  endfunction

  // Append one expectation at the tail of the due queue
  function automatic void add_due(sorted_rec_t due);
    sorted_due = {sorted_due, due};
  endfunction

  // Take one accepted record into the predictor. On a final mark the held set
  // is exchange-sorted in the same i/j pair order the block uses, and the
  // sorted records are queued unless the caller supplies its own.
  task automatic absorb_record(input esbk_pkg::rec_t rec, input logic fin, input bit queue_it);
    esbk_pkg::rec_t swap_rec;
    sorted_rec_t    out_rec;
    if (held_count < DEPTH) begin
      held_recs[held_count] = rec;
      held_count++;
    end
    if (fin) begin
      for (int i = 0; i + 1 < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          if (!key_precedes(held_recs[i].key, held_recs[j].key)) begin
            swap_rec     = held_recs[i];
            held_recs[i] = held_recs[j];
            held_recs[j] = swap_rec;
          end
        end
      end
      if (queue_it) begin
        for (int k = 0; k < held_count; k++) begin
          out_rec.rec  = held_recs[k];
          out_rec.last = (k + 1 == held_count);
          add_due(out_rec);
        end
      end
      held_count = 0;
    end
  endtask

  // Offer one record until the block takes it. Random sender gaps go in
  // front, except inside the quiet window. Fields carry noise while start is low.
  task automatic send_record(input esbk_pkg::rec_t rec, input logic fin);
    if (xfer_count < QUIET_FROM || xfer_count >= QUIET_TO) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start        <= 1'b0;
        record_key_i <= KEY_W'($urandom);
        record_tag_i <= TAG_W'($urandom);
        is_final_i   <= 1'($urandom_range(1));
        @(posedge clk_i);
      end
    end
    start        <= 1'b1;
    record_key_i <= rec.key;
    record_tag_i <= rec.tag;
    is_final_i   <= fin;
    @(posedge clk_i);
    // transfer happens at the first edge that sees busy low
    while (busy !== 1'b0) @(posedge clk_i);
    xfer_count++;
  endtask

  // Stop offering and wait until every queued result has come out and the
  // block has gone idle, then a short settle pause.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sorted_due.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sort_mode write; only called from an idle block
  task automatic write_mode(input logic mode);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= 1'($urandom_range(1));
    sort_desc = mode;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(key_mix_e mix);
    case (mix)
      MIX_TIES: begin
        return KEY_W'($urandom_range(3));
      end
      MIX_EDGES: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KEY_W-1){1'b0}}};
          default: return KEY_W'($urandom);
        endcase
      end
      default: begin
        return KEY_W'($urandom);
      end
    endcase
  endfunction

  // Set sizes: mostly short, some exactly full, a few overflowing the store
  function automatic int pick_set_len();
    int roll;
    roll = int'($urandom_range(99));
    if (roll < 70) return int'($urandom_range(6, 1));
    if (roll < 85) return int'($urandom_range(DEPTH - 1, 7));
    if (roll < 93) return int'(DEPTH);
    return int'($urandom_range(DEPTH + 5, DEPTH + 1));
  endfunction

  // Output checker: every strobe is a transfer and must match the oldest
  // queued expectation field by field.
  sorted_rec_t due_rec;
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result key %h tag %h last %b", $time,
                 sorted_key_o, sorted_tag_o, end_of_run_o);
        fail_count++;
      end else begin
        due_rec = sorted_due.pop_front();
        if (result_valid_o !== 1'b1) begin
          $display("%0t: result_valid_o expected 1 actual %b", $time, result_valid_o);
          fail_count++;
        end
        if (sorted_key_o !== due_rec.rec.key) begin
          $display("%0t: sorted_key expected %h actual %h", $time,
                   due_rec.rec.key, sorted_key_o);
          fail_count++;
        end
        if (sorted_tag_o !== due_rec.rec.tag) begin
          $display("%0t: sorted_tag expected %h actual %h", $time,
                   due_rec.rec.tag, sorted_tag_o);
          fail_count++;
        end
        if (end_of_run_o !== due_rec.last) begin
          $display("%0t: end_of_run expected %b actual %b", $time,
                   due_rec.last, end_of_run_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t      row;
    esbk_pkg::rec_t rec;
    sorted_rec_t    typed_rec;
    key_mix_e       mix;
    int             set_len;
    int             set_no;
    int             rand_sent;

    // Reset held low, then released at an edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_PLAN[r];
      if (row.cfg != CFG_KEEP) begin
        drain_results();
        write_mode(row.cfg == CFG_DESC ? MODE_DESC : MODE_ASC);
      end
      for (int c = 0; c < int'(row.rep); c++) begin
        rec.key = row.key + KEY_W'(c * 16'h3C5A);
        rec.tag = row.tag + TAG_W'(c);
        send_record(rec, row.fin && (c + 1 == int'(row.rep)));
        absorb_record(rec, row.fin && (c + 1 == int'(row.rep)), !row.typed);
      end
      if (row.typed) begin
        typed_rec.rec.key = row.exp_key;
        typed_rec.rec.tag = row.exp_tag;
        typed_rec.last    = 1'b1;
        add_due(typed_rec);
      end
    end

    // Random sets. The first one overflows the store so non-final records
    // and the final mark are both dropped; sort_mode changes now and then.
    set_no    = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      set_len = (set_no == 0) ? int'(DEPTH) + 3 : pick_set_len();
      if (set_no == 0 || $urandom_range(4) == 0) begin
        drain_results();
        write_mode((set_no == 0) ? MODE_ASC : 1'($urandom_range(1)));
      end
      mix = key_mix_e'($urandom_range(2));
      for (int k = 0; k < set_len; k++) begin
        rec.key = pick_key(mix);
        rec.tag = TAG_W'($urandom);
        send_record(rec, k + 1 == set_len);
        absorb_record(rec, k + 1 == set_len, 1'b1);
        rand_sent++;
      end
      set_no++;
    end

    // Wind down: all results out, then a latency's worth of quiet
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
